// ===== rtl/rounded_rect_alpha_fill_top_macros.svh =====
// Assertion macros used by the RTL of the rounded rectangle fill.
`ifndef ROUNDED_RECT_ALPHA_FILL_TOP_MACROS_SVH
`define ROUNDED_RECT_ALPHA_FILL_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RRA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rra_pkg.sv =====
package rra_pkg;

   localparam int COORD_BITS = 12;
   localparam int REG_W      = 13;
   localparam int RAD_W      = 12;
   localparam int SPAN_W     = 17;
   localparam int EX_W       = COORD_BITS;
   localparam int D2_W       = 2 * EX_W + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int NUM_W      = 16;
   localparam int QUO_W      = 8;
   localparam int LANES      = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RECT_LEFT     = 3'd0,
      CSR_RECT_TOP      = 3'd1,
      CSR_RECT_WIDTH    = 3'd2,
      CSR_RECT_HEIGHT   = 3'd3,
      CSR_CORNER_RADIUS = 3'd4,
      CSR_FILL_RGBA     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rgba_type;

   typedef struct packed {
      logic     in_rect;
      rgba_type dest;
   } carry_type;

endpackage

// ===== rtl/rra_req_if.sv =====
interface rra_req_if
   import rra_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pix_x;
   logic [COORD_BITS-1:0] pix_y;
   logic [7:0]            dest_red;
   logic [7:0]            dest_green;
   logic [7:0]            dest_blue;
   logic [7:0]            dest_alpha;

   modport source (output valid, pix_x, pix_y, dest_red, dest_green, dest_blue, dest_alpha,
                   input ready);
   modport sink (input valid, pix_x, pix_y, dest_red, dest_green, dest_blue, dest_alpha,
                 output ready);
endinterface

// ===== rtl/rra_rsp_if.sv =====
interface rra_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] new_red;
   logic [7:0] new_green;
   logic [7:0] new_blue;
   logic [7:0] new_alpha;
   logic       was_drawn;

   modport source (output valid, new_red, new_green, new_blue, new_alpha, was_drawn,
                   input ready);
   modport sink (input valid, new_red, new_green, new_blue, new_alpha, was_drawn,
                 output ready);
endinterface

// ===== rtl/rounded_rect_alpha_fill_top.sv =====
// Anti-aliased rounded rectangle fill, one destination pixel per transfer. Each pixel
// enters a pipeline of DIST_FRAC_BITS + 30 register stages (38 with the default settings)
// and a new pixel is taken in every cycle while the pipeline is not held. The depth is
// set by the square root, which resolves one bit of the distance per stage, and by the
// colour division, which resolves one quotient bit per stage. When a result waits on a
// result channel that is not ready, the whole pipeline holds. Registers are to be written
// through the csr port only while no pixel is in flight; the block does not enforce this.
module rounded_rect_alpha_fill_top
   import rra_pkg::*;
#(
   parameter int DIST_FRAC_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   rra_req_if.sink               req_chan,
   rra_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   `include "rounded_rect_alpha_fill_top_macros.svh"

   localparam int RW      = (D2_W + 1) / 2 + DIST_FRAC_BITS;
   localparam int SQ_W    = 2 * RW;
   localparam int REM_W   = RW + 2;
   localparam int COV_W   = DIST_FRAC_BITS + 1;
   localparam int NS      = RW + 17;
   localparam int ST_SQ   = 2 + RW;
   localparam int ST_H    = 6 + RW;
   localparam int CHK_W   = SQ_W + 2;

   // Configuration registers.
   logic signed [REG_W-1:0] left_ff, top_ff;
   logic [REG_W-1:0]        width_ff, height_ff;
   logic [RAD_W-1:0]        radius_ff;
   rgba_type                fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         top_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         radius_ff <= '0;
         fill_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_RECT_LEFT:     left_ff   <= signed'(csr_wdata[REG_W-1:0]);
            CSR_RECT_TOP:      top_ff    <= signed'(csr_wdata[REG_W-1:0]);
            CSR_RECT_WIDTH:    width_ff  <= csr_wdata[REG_W-1:0];
            CSR_RECT_HEIGHT:   height_ff <= csr_wdata[REG_W-1:0];
            CSR_CORNER_RADIUS: radius_ff <= csr_wdata[RAD_W-1:0];
            CSR_FILL_RGBA:     fill_ff   <= rgba_type'(csr_wdata);
            default: ;
         endcase
      end
   end

   // Geometry from registers that the user must keep constant while pixels are in flight.
   logic [RAD_W-1:0]         rad;
   logic signed [SPAN_W-1:0] left_s, right_s, top_s, bottom_s;
   logic signed [SPAN_W-1:0] lo_x, hi_x, lo_y, hi_y, rad_s;
   logic [RW-1:0]            limit;

   always_comb begin
      rad = radius_ff;
      if (rad > width_ff[REG_W-1:1]) rad = width_ff[REG_W-1:1];
      if (rad > height_ff[REG_W-1:1]) rad = height_ff[REG_W-1:1];
      rad_s    = signed'(SPAN_W'(rad));
      left_s   = SPAN_W'(left_ff);
      top_s    = SPAN_W'(top_ff);
      right_s  = left_s + signed'(SPAN_W'(width_ff));
      bottom_s = top_s + signed'(SPAN_W'(height_ff));
      lo_x     = left_s + rad_s;
      hi_x     = right_s - rad_s - SPAN_W'(1);
      lo_y     = top_s + rad_s;
      hi_y     = bottom_s - rad_s - SPAN_W'(1);
      limit    = RW'({rad, {DIST_FRAC_BITS{1'b0}}}) + (RW'(1) << (DIST_FRAC_BITS - 1));
   end

   // Pipeline control.
   logic            adv;
   logic [NS-1:0]   vld_ff, vld_in;

   assign adv            = !vld_ff[NS-1] || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign vld_in         = {vld_ff[NS-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // Stage A: inside test, clamp into the inner rectangle, offsets.
   logic signed [SPAN_W-1:0] xs, ys, cx, cy, dx, dy;
   logic [EX_W-1:0]          ex_in, ey_in, ex_a_ff, ey_a_ff;
   carry_type                car_in, car_a_ff;

   always_comb begin
      xs = signed'(SPAN_W'(req_chan.pix_x));
      ys = signed'(SPAN_W'(req_chan.pix_y));
      cx = (xs < lo_x) ? lo_x : xs;
      if (cx > hi_x) cx = hi_x;
      cy = (ys < lo_y) ? lo_y : ys;
      if (cy > hi_y) cy = hi_y;
      dx = xs - cx;
      dy = ys - cy;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      ex_in = dx[EX_W-1:0];
      ey_in = dy[EX_W-1:0];
      car_in.in_rect = (xs >= left_s) && (xs < right_s) && (ys >= top_s) && (ys < bottom_s);
      car_in.dest    = {req_chan.dest_red, req_chan.dest_green,
                        req_chan.dest_blue, req_chan.dest_alpha};
   end

   // Stages B and C: squares, then their sum.
   logic [2*EX_W-1:0] sqx_b_ff, sqy_b_ff;
   logic [D2_W-1:0]   d2_c_ff;
   carry_type         car_b_ff, car_c_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ex_a_ff  <= ex_in;
         ey_a_ff  <= ey_in;
         car_a_ff <= car_in;
         sqx_b_ff <= ex_a_ff * ex_a_ff;
         sqy_b_ff <= ey_a_ff * ey_a_ff;
         car_b_ff <= car_a_ff;
         d2_c_ff  <= D2_W'(sqx_b_ff) + D2_W'(sqy_b_ff);
         car_c_ff <= car_b_ff;
      end
   end

   // Square root, one result bit per stage.
   logic [RW-1:0]    sq_root_ff [RW];
   logic [REM_W-1:0] sq_rem_ff  [RW];
   logic [D2_W-1:0]  sq_d2_ff   [RW];
   carry_type        sq_car_ff  [RW];

   for (genvar i = 0; i < RW; i++) begin : g_sqrt
      logic [RW-1:0]    root_p, root_in;
      logic [REM_W-1:0] rem_p, rem_sh, trial, rem_in;
      logic [D2_W-1:0]  d2_p;
      carry_type        car_p;
      logic [SQ_W-1:0]  radicand;
      logic             ge;

      if (i == 0) begin : g_first
         assign root_p = '0;
         assign rem_p  = '0;
         assign d2_p   = d2_c_ff;
         assign car_p  = car_c_ff;
      end else begin : g_next
         assign root_p = sq_root_ff[i-1];
         assign rem_p  = sq_rem_ff[i-1];
         assign d2_p   = sq_d2_ff[i-1];
         assign car_p  = sq_car_ff[i-1];
      end

      always_comb begin
         radicand = SQ_W'(d2_p) << (2 * DIST_FRAC_BITS);
         rem_sh   = {rem_p[REM_W-3:0], radicand[SQ_W-1-2*i -: 2]};
         trial    = {root_p, 2'b01};
         ge       = rem_sh >= trial;
         rem_in   = ge ? rem_sh - trial : rem_sh;
         root_in  = {root_p[RW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_root_ff[i] <= root_in;
            sq_rem_ff[i]  <= rem_in;
            sq_d2_ff[i]   <= d2_p;
            sq_car_ff[i]  <= car_p;
         end
      end
   end

   // Stage E: edge test and coverage.
   logic [RW-1:0]    root_val, diff;
   logic [COV_W-1:0] cov_in, cov_e_ff;
   logic             drawn_e_ff;
   carry_type        car_e_ff;

   always_comb begin
      root_val = sq_root_ff[RW-1];
      diff     = limit - root_val;
      cov_in   = (diff > RW'(1 << DIST_FRAC_BITS)) ? COV_W'(1 << DIST_FRAC_BITS)
                                                    : diff[COV_W-1:0];
   end

   // Stages F, G and H: shaded alpha, kept destination alpha and the composite alpha.
   logic [7:0]             a_f_ff, a_g_ff, a_h_ff, back_h_ff;
   logic [COV_W+7:0]       shade;
   logic [NUM_W-1:0]       p_g_ff;
   logic [NUM_W:0]         p_rnd;
   logic [8:0]             sum_in, sum_h_ff;
   logic                   drawn_f_ff, drawn_g_ff, drawn_h_ff;
   carry_type              car_f_ff, car_g_ff, car_h_ff;

   always_comb begin
      shade  = fill_ff.alpha * cov_e_ff;
      p_rnd  = (NUM_W+1)'(p_g_ff) + (NUM_W+1)'(1) + (NUM_W+1)'(p_g_ff[NUM_W-1:8]);
      sum_in = 9'(a_g_ff) + 9'(p_rnd[NUM_W-1:8]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cov_e_ff   <= cov_in;
         drawn_e_ff <= sq_car_ff[RW-1].in_rect && (root_val <= limit);
         car_e_ff   <= sq_car_ff[RW-1];
         a_f_ff     <= shade[DIST_FRAC_BITS +: 8];
         drawn_f_ff <= drawn_e_ff;
         car_f_ff   <= car_e_ff;
         a_g_ff     <= a_f_ff;
         p_g_ff     <= car_f_ff.dest.alpha * (8'd255 - a_f_ff);
         drawn_g_ff <= drawn_f_ff;
         car_g_ff   <= car_f_ff;
         a_h_ff     <= a_g_ff;
         back_h_ff  <= p_rnd[NUM_W-1:8];
         sum_h_ff   <= sum_in;
         drawn_h_ff <= drawn_g_ff;
         car_h_ff   <= car_g_ff;
      end
   end

   // Stage I: colour numerators.
   logic [7:0]       fill_col [LANES];
   logic [7:0]       dest_col [LANES];
   logic [NUM_W-1:0] num_i_ff [LANES];
   logic [7:0]       sum_i_ff;
   logic             drawn_i_ff;
   carry_type        car_i_ff;

   always_comb begin
      fill_col[0] = fill_ff.red;
      fill_col[1] = fill_ff.green;
      fill_col[2] = fill_ff.blue;
      dest_col[0] = car_h_ff.dest.red;
      dest_col[1] = car_h_ff.dest.green;
      dest_col[2] = car_h_ff.dest.blue;
   end

   for (genvar c = 0; c < LANES; c++) begin : g_num
      always_ff @(posedge clock) begin
         if (adv) begin
            num_i_ff[c] <= fill_col[c] * a_h_ff + dest_col[c] * back_h_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_i_ff   <= sum_h_ff[7:0];
         drawn_i_ff <= drawn_h_ff;
         car_i_ff   <= car_h_ff;
      end
   end

   // Colour division, one quotient bit per stage in each lane.
   logic [NUM_W-1:0] dv_rem_ff [QUO_W][LANES];
   logic [QUO_W-1:0] dv_quo_ff [QUO_W][LANES];
   logic [7:0]       dv_sum_ff [QUO_W];
   logic             dv_drawn_ff [QUO_W];
   carry_type        dv_car_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      logic [7:0] sum_p;
      logic       drawn_p;
      carry_type  car_p;

      if (k == 0) begin : g_first
         assign sum_p   = sum_i_ff;
         assign drawn_p = drawn_i_ff;
         assign car_p   = car_i_ff;
      end else begin : g_next
         assign sum_p   = dv_sum_ff[k-1];
         assign drawn_p = dv_drawn_ff[k-1];
         assign car_p   = dv_car_ff[k-1];
      end

      for (genvar c = 0; c < LANES; c++) begin : g_lane
         logic [NUM_W-1:0] rem_p, dsh;
         logic [QUO_W-1:0] quo_p;
         logic             ge;

         if (k == 0) begin : g_first
            assign rem_p = num_i_ff[c];
            assign quo_p = '0;
         end else begin : g_next
            assign rem_p = dv_rem_ff[k-1][c];
            assign quo_p = dv_quo_ff[k-1][c];
         end

         assign dsh = NUM_W'(sum_p) << (QUO_W - 1 - k);
         assign ge  = rem_p >= dsh;

         always_ff @(posedge clock) begin
            if (adv) begin
               dv_rem_ff[k][c] <= ge ? rem_p - dsh : rem_p;
               dv_quo_ff[k][c] <= {quo_p[QUO_W-2:0], ge};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_sum_ff[k]   <= sum_p;
            dv_drawn_ff[k] <= drawn_p;
            dv_car_ff[k]   <= car_p;
         end
      end
   end

   // Output stage.
   rgba_type  out_in, out_ff;
   logic      drawn_o_ff;
   carry_type car_l;
   logic      mix;

   always_comb begin
      car_l = dv_car_ff[QUO_W-1];
      mix   = dv_drawn_ff[QUO_W-1] && (dv_sum_ff[QUO_W-1] != 8'd0);
      out_in.red   = mix ? dv_quo_ff[QUO_W-1][0] : car_l.dest.red;
      out_in.green = mix ? dv_quo_ff[QUO_W-1][1] : car_l.dest.green;
      out_in.blue  = mix ? dv_quo_ff[QUO_W-1][2] : car_l.dest.blue;
      out_in.alpha = dv_drawn_ff[QUO_W-1] ? dv_sum_ff[QUO_W-1] : car_l.dest.alpha;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff     <= out_in;
         drawn_o_ff <= dv_drawn_ff[QUO_W-1];
      end
   end

   assign rsp_chan.valid     = vld_ff[NS-1];
   assign rsp_chan.new_red   = out_ff.red;
   assign rsp_chan.new_green = out_ff.green;
   assign rsp_chan.new_blue  = out_ff.blue;
   assign rsp_chan.new_alpha = out_ff.alpha;
   assign rsp_chan.was_drawn = drawn_o_ff;

   logic [CHK_W-1:0] chk_lo, chk_hi, chk_rad;

   assign chk_lo  = CHK_W'(root_val) * CHK_W'(root_val);
   assign chk_hi  = (CHK_W'(root_val) + CHK_W'(1)) * (CHK_W'(root_val) + CHK_W'(1));
   assign chk_rad = CHK_W'(sq_d2_ff[RW-1]) << (2 * DIST_FRAC_BITS);

   `RRA_ASSERT_NEXT(a_stall_holds, !adv, vld_ff == $past(vld_ff), "pipeline moved while stalled")
   `RRA_ASSERT_NOW(a_sqrt_floor, vld_ff[ST_SQ], (chk_lo <= chk_rad) && (chk_hi > chk_rad), "square root is not the floor")
   `RRA_ASSERT_NOW(a_sum_range, vld_ff[ST_H], sum_h_ff <= 9'd255, "composite alpha exceeds 255")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
   import rra_pkg::*;
();

   localparam int LATENCY = 38;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       drawn;
   } pixel_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rra_req_if req_chan ();
   rra_rsp_if rsp_chan ();

   rounded_rect_alpha_fill_top u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   int left_q, top_q, width_q, height_q, radius_q;
   logic [31:0] fill_q;
   pixel_out_type expected_pixels[$];
   int errors = 0;
   int cycles = 0;
   int pixels_sent = 0;
   int pixels_drawn = 0;
   int sink_wait = 0;
   logic rsp_taken = 1'b0;

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic pixel_out_type fill_pixel(int x, int y, logic [31:0] dest);
      pixel_out_type o;
      int rad, lo, hi, cx, cy, ex, ey;
      longint unsigned d2, root_d, lim, cov;
      int unsigned fr, fg, fb, fa, a, back, total, dr, dg, db, da;
      dr = dest[31:24]; dg = dest[23:16]; db = dest[15:8]; da = dest[7:0];
      o = {dest, 1'b0};
      if (x >= left_q && x < left_q + width_q && y >= top_q && y < top_q + height_q) begin
         rad = radius_q;
         if (rad > width_q / 2) rad = width_q / 2;
         if (rad > height_q / 2) rad = height_q / 2;
         lo = left_q + rad; hi = left_q + width_q - rad - 1;
         cx = x < lo ? lo : x;
         if (cx > hi) cx = hi;
         lo = top_q + rad; hi = top_q + height_q - rad - 1;
         cy = y < lo ? lo : y;
         if (cy > hi) cy = hi;
         ex = x - cx; if (ex < 0) ex = -ex;
         ey = y - cy; if (ey < 0) ey = -ey;
         d2 = longint'(ex) * ex + longint'(ey) * ey;
         root_d = int_sqrt(d2 << 16);
         lim = (longint'(rad) << 8) + 128;
         if (root_d <= lim) begin
            fr = fill_q[31:24]; fg = fill_q[23:16]; fb = fill_q[15:8]; fa = fill_q[7:0];
            cov = lim - root_d;
            if (cov > 256) cov = 256;
            a = 32'((fa * cov) >> 8);
            back = da * (255 - a) / 255;
            total = a + back;
            if (total != 0) begin
               o.red = 8'((fr * a + dr * back) / total);
               o.green = 8'((fg * a + dg * back) / total);
               o.blue = 8'((fb * a + db * back) / total);
            end
            o.alpha = total[7:0];
            o.drawn = 1'b1;
         end
      end
      return o;
   endfunction

   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_RECT_LEFT:     left_q = $signed(value[12:0]);
         CSR_RECT_TOP:      top_q = $signed(value[12:0]);
         CSR_RECT_WIDTH:    width_q = value[12:0];
         CSR_RECT_HEIGHT:   height_q = value[12:0];
         CSR_CORNER_RADIUS: radius_q = value[11:0];
         CSR_FILL_RGBA:     fill_q = value;
         default: ;
      endcase
   endtask

   task automatic set_shape(int l, int t, int w, int h, int r, logic [31:0] rgba);
      wait (expected_pixels.size() == 0);
      repeat (LATENCY + 4) @(negedge clock);
      write_reg(CSR_RECT_LEFT, l);
      write_reg(CSR_RECT_TOP, t);
      write_reg(CSR_RECT_WIDTH, w);
      write_reg(CSR_RECT_HEIGHT, h);
      write_reg(CSR_CORNER_RADIUS, r);
      write_reg(CSR_FILL_RGBA, rgba);
   endtask

   task automatic send_pixel(int x, int y, logic [31:0] dest, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.pix_x = COORD_BITS'(x);
      req_chan.pix_y = COORD_BITS'(y);
      {req_chan.dest_red, req_chan.dest_green, req_chan.dest_blue, req_chan.dest_alpha} = dest;
      do @(posedge clock); while (!req_chan.ready);
      expected_pixels.push_back(fill_pixel(x, y, dest));
      pixels_sent++;
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   task automatic idle_source();
      req_chan.valid = 1'b0;
   endtask

   always @(negedge clock) begin
      int draw;
      draw = 0;
      if (rsp_taken && $urandom_range(0, 3) == 0) draw = $urandom_range(0, 13);
      if (sink_wait > 0) begin
         rsp_chan.ready <= 1'b0;
         sink_wait <= sink_wait - 1;
      end else if (draw > 0) begin
         rsp_chan.ready <= 1'b0;
         sink_wait <= draw - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      pixel_out_type got, want;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("rounded_rect_alpha_fill_top: mismatch");
         $finish;
      end
      rsp_taken <= !reset && rsp_chan.valid && rsp_chan.ready;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.new_red, rsp_chan.new_green, rsp_chan.new_blue,
                rsp_chan.new_alpha, rsp_chan.was_drawn};
         if (expected_pixels.size() == 0) begin
            $display("%0t unexpected result %h", $realtime, got);
            errors++;
         end else begin
            want = expected_pixels.pop_front();
            if (got.drawn) pixels_drawn++;
            if (got !== want) begin
               $display("%0t expected r%h g%h b%h a%h d%b, got r%h g%h b%h a%h d%b",
                        $realtime, want.red, want.green, want.blue, want.alpha, want.drawn,
                        got.red, got.green, got.blue, got.alpha, got.drawn);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      set_shape(0, 0, 0, 0, 0, 32'h0);
      send_pixel(0, 0, 32'hFFFFFFFF, 0);
      set_shape(10, 20, 40, 30, 8, 32'hFF8040FF);
      send_pixel(10, 20, 32'h00000000, 0);
      send_pixel(9, 20, 32'h12345678, 0);
      send_pixel(49, 49, 32'hABCDEF01, 0);
      send_pixel(50, 49, 32'hABCDEF01, 0);
      send_pixel(30, 35, 32'h11223344, 0);
      send_pixel(12, 22, 32'h808080FF, 0);
      send_pixel(4095, 4095, 32'hFFFFFFFF, 0);
      set_shape(100, 100, 20, 20, 2000, 32'h000000FF);
      send_pixel(100, 100, 32'hFFFFFF00, 0);
      send_pixel(110, 110, 32'hFFFFFF00, 0);
      send_pixel(119, 105, 32'h000000FF, 0);
      set_shape(5, 5, 10, 10, 10, 32'h00000000);
      send_pixel(7, 7, 32'h55555500, 0);
      send_pixel(10, 10, 32'h55555580, 0);
      set_shape(-4096, -4096, 4096, 4096, 2048, 32'hFFFFFF80);
      send_pixel(0, 0, 32'h01020304, 0);
      set_shape(4095, 4095, 4096, 4096, 0, 32'hFFFFFFFF);
      send_pixel(4095, 4095, 32'h00000000, 0);
      send_pixel(4094, 4095, 32'h00000000, 0);
      set_shape(0, 0, 4096, 4096, 0, 32'h7F7F7F7F);
      send_pixel(4095, 0, 32'hFF00FF00, 0);
      send_pixel(0, 4095, 32'h00FF00FF, 0);
      idle_source();
   endtask

   task automatic test_random();
      int px, py, w, h;
      for (int phase = 0; phase < 12; phase++) begin
         w = (phase == 11) ? 4096 : $urandom_range(0, 80);
         h = (phase == 11) ? 4096 : $urandom_range(0, 80);
         set_shape($urandom_range(0, 4000) - 40, $urandom_range(0, 4000) - 40, w, h,
                   $urandom_range(0, 4) == 0 ? 4095 : $urandom_range(0, 45), $urandom);
         for (int n = 0; n < 120; n++) begin
            if ($urandom_range(0, 9) < 8 && w > 0 && h > 0) begin
               px = left_q + $urandom_range(0, w + 3) - 2;
               py = top_q + $urandom_range(0, h + 3) - 2;
               if (px < 0 || px > 4095) px = $urandom_range(0, 4095);
               if (py < 0 || py > 4095) py = $urandom_range(0, 4095);
            end else begin
               px = $urandom_range(0, 4095);
               py = $urandom_range(0, 4095);
            end
            send_pixel(px, py, $urandom, n >= 30);
         end
         idle_source();
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.pix_x = '0;
      req_chan.pix_y = '0;
      req_chan.dest_red = '0;
      req_chan.dest_green = '0;
      req_chan.dest_blue = '0;
      req_chan.dest_alpha = '0;
      left_q = 0; top_q = 0; width_q = 0; height_q = 0; radius_q = 0; fill_q = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random();
      wait (expected_pixels.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d pixels over 19 rectangle settings; %0d results were drawn.",
               pixels_sent, pixels_drawn);
      if (errors == 0 && expected_pixels.size() == 0) begin
         $display("rounded_rect_alpha_fill_top: match");
      end else begin
         $display("rounded_rect_alpha_fill_top: mismatch");
      end
      $finish;
   end

endmodule
